// ===== rtl/rrd_pkg.sv =====
// shared types, constants and step functions for the refraction pipeline
package rrd_pkg;

  // pipeline depths
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 31;
  localparam int UnitLat   = 5 + SqrtSteps + 1 + DivSteps + 1;
  localparam int TailLat   = 8 + SqrtSteps + 5;
  localparam int TotalLat  = UnitLat + TailLat;

  // fixed-point constants
  localparam logic signed [63:0] Q30One = 64'sd1073741824;
  localparam logic signed [20:0] EpsQ32 = 21'sd429497;

  // one step of the digit-by-digit square root
  typedef struct packed {
    logic [63:0] num;
    logic [63:0] res;
  } sqrt_st_t;

  // one step of the restoring divider
  typedef struct packed {
    logic [31:0] rem;
    logic        q;
  } div_st_t;

  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [63:0] probe);
    sqrt_st_t o;
    logic [63:0] trial;
    trial = s.res + probe;
    if (s.num >= trial) begin
      o.num = s.num - trial;
      o.res = (s.res >> 1) + probe;
    end else begin
      o.num = s.num;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  function automatic div_st_t div_step(logic [31:0] rem, logic nb, logic [31:0] len);
    div_st_t o;
    logic [32:0] t;
    t = {rem, nb};
    if (t >= {1'b0, len}) begin
      o.rem = 32'(t - {1'b0, len});
      o.q   = 1'b1;
    end else begin
      o.rem = t[31:0];
      o.q   = 1'b0;
    end
    return o;
  endfunction

  // right shift rounding half away from zero
  function automatic logic signed [63:0] rshr(logic signed [63:0] v, int unsigned n);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? 64'(-v) : 64'(v);
    m   = (mag + (64'd1 << (n - 1))) >> n;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== rtl/rrd_unitize.sv =====
// pipelined scaling of one vector to a Q1.30 unit vector
module rrd_unitize (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] v [0:2],
  output logic signed [31:0] u [0:2],
  output logic               zero
);
  import rrd_pkg::*;

  logic [31:0] a_m [0:2];
  logic [2:0]  a_neg;
  logic [31:0] b_m [0:2];
  logic [2:0]  b_neg;
  logic [31:0] b_mx;
  logic [4:0]  sh;
  logic [31:0] c_m [0:2];
  logic [2:0]  c_neg;
  logic        c_zero;
  logic [63:0] d_sq [0:2];
  logic [31:0] d_m [0:2];
  logic [2:0]  d_neg;
  logic        d_zero;

  sqrt_st_t    sq      [0:SqrtSteps];
  logic [31:0] sq_m    [0:SqrtSteps][0:2];
  logic [2:0]  sq_neg  [0:SqrtSteps];
  logic        sq_zero [0:SqrtSteps];

  logic [31:0] dv_rem  [0:DivSteps][0:2];
  logic [30:0] dv_low  [0:DivSteps][0:2];
  logic [30:0] dv_q    [0:DivSteps][0:2];
  logic [31:0] dv_len  [0:DivSteps];
  logic [2:0]  dv_neg  [0:DivSteps];
  logic        dv_zero [0:DivSteps];

  logic [31:0] len;
  assign len = sq[SqrtSteps].res[31:0];

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_m[i]   <= v[i][31] ? 32'(-v[i]) : 32'(v[i]);
        a_neg[i] <= v[i][31];
      end
    end
  end

  // largest magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      b_m   <= a_m;
      b_neg <= a_neg;
      b_mx  <= (a_m[0] > a_m[1]) ? ((a_m[0] > a_m[2]) ? a_m[0] : a_m[2])
                                 : ((a_m[1] > a_m[2]) ? a_m[1] : a_m[2]);
    end
  end

  // shift count that lifts the largest magnitude to at least 2^30
  always_comb begin
    logic [4:0] msb;
    msb = '0;
    for (int k = 0; k < 32; k++) begin
      if (b_mx[k]) msb = 5'(k);
    end
    sh = (msb >= 5'd30) ? 5'd0 : 5'(5'd30 - msb);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) c_m[i] <= b_m[i] << sh;
      c_neg  <= b_neg;
      c_zero <= (b_mx == '0);
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) d_sq[i] <= 64'(c_m[i]) * 64'(c_m[i]);
      d_m    <= c_m;
      d_neg  <= c_neg;
      d_zero <= c_zero;
    end
  end

  // sum of squares enters the root pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].num  <= d_sq[0] + d_sq[1] + d_sq[2];
      sq[0].res  <= '0;
      sq_m[0]    <= d_m;
      sq_neg[0]  <= d_neg;
      sq_zero[0] <= d_zero;
    end
  end

  // root, one result bit per stage
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (en) begin
        sq[j+1]      <= sqrt_step(sq[j], 64'd1 << (62 - 2 * j));
        sq_m[j+1]    <= sq_m[j];
        sq_neg[j+1]  <= sq_neg[j];
        sq_zero[j+1] <= sq_zero[j];
      end
    end
  end

  // rounded numerators, high part seeds the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [63:0] nm;
        nm = ({32'd0, sq_m[SqrtSteps][i]} << 30) + {33'd0, len[31:1]};
        dv_rem[0][i] <= nm[62:31];
        dv_low[0][i] <= nm[30:0];
        dv_q[0][i]   <= '0;
      end
      dv_len[0]  <= len;
      dv_neg[0]  <= sq_neg[SqrtSteps];
      dv_zero[0] <= sq_zero[SqrtSteps];
    end
  end

  // division, one quotient bit per stage
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          div_st_t st;
          st = div_step(dv_rem[j][i], dv_low[j][i][DivSteps-1-j], dv_len[j]);
          dv_rem[j+1][i] <= st.rem;
          dv_q[j+1][i]   <= {dv_q[j][i][DivSteps-2:0], st.q};
          dv_low[j+1][i] <= dv_low[j][i];
        end
        dv_len[j+1]  <= dv_len[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_zero[j+1] <= dv_zero[j];
      end
    end
  end

  // restore signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u[i] <= dv_neg[DivSteps][i] ? -$signed({1'b0, dv_q[DivSteps][i]})
                                    : $signed({1'b0, dv_q[DivSteps][i]});
      end
      zero <= dv_zero[DivSteps];
    end
  end

endmodule

// ===== rtl/ray_refract_direction_unit.sv =====
// Snell refraction pipeline: unit vectors, refracted direction and offset origin
// Throughput: one word per cycle while the output is not stalled; the pipeline is
// set by three 32-stage square root units and a 31-stage divider per vector
// component.
// A stalled output word freezes the whole pipeline; nothing is dropped.
// Reset (rst, synchronous) clears all stage valid bits; data registers are not reset.
module ray_refract_direction_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] normal_z,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic        [19:0] index_ratio,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_dir_x,
  output logic signed [31:0] out_dir_y,
  output logic signed [31:0] out_dir_z,
  output logic signed [31:0] origin_x,
  output logic signed [31:0] origin_y,
  output logic signed [31:0] origin_z,
  output logic               internal_reflection,
  output logic               degenerate
);
  import rrd_pkg::*;

  logic                en;
  logic [TotalLat-1:0] vld;

  logic signed [31:0] dv [0:2];
  logic signed [31:0] nv [0:2];
  logic signed [31:0] ud [0:2];
  logic signed [31:0] un [0:2];
  logic               zd;
  logic               zn;

  logic signed [31:0] pu_pos [0:UnitLat-1][0:2];
  logic        [19:0] pu_r   [0:UnitLat-1];

  logic signed [63:0] t1_dn [0:2];
  logic signed [31:0] t1_d [0:2];
  logic signed [31:0] t1_n [0:2];
  logic signed [31:0] t1_pos [0:2];
  logic        [19:0] t1_r;
  logic               t1_deg;

  logic signed [63:0] t2_dot;
  logic signed [31:0] t2_d [0:2];
  logic signed [31:0] t2_n [0:2];
  logic signed [31:0] t2_pos [0:2];
  logic        [19:0] t2_r;
  logic               t2_deg;

  logic signed [31:0] t3_c;
  logic signed [31:0] t3_d [0:2];
  logic signed [31:0] t3_n [0:2];
  logic signed [31:0] t3_pos [0:2];
  logic        [19:0] t3_r;
  logic               t3_deg;

  logic signed [63:0] t4_cc;
  logic signed [63:0] t4_nc [0:2];
  logic signed [31:0] t4_d [0:2];
  logic signed [31:0] t4_n [0:2];
  logic signed [31:0] t4_pos [0:2];
  logic        [19:0] t4_r;
  logic               t4_deg;

  logic        [30:0] t5_omc;
  logic signed [32:0] t5_tang [0:2];
  logic signed [31:0] t5_n [0:2];
  logic signed [31:0] t5_pos [0:2];
  logic        [19:0] t5_r;
  logic               t5_deg;

  logic        [50:0] t6_rom;
  logic signed [53:0] t6_rtp [0:2];
  logic signed [31:0] t6_n [0:2];
  logic signed [31:0] t6_pos [0:2];
  logic        [19:0] t6_r;
  logic               t6_deg;

  logic        [54:0] t7_rr;
  logic signed [37:0] t7_rt [0:2];
  logic signed [31:0] t7_n [0:2];
  logic signed [31:0] t7_pos [0:2];
  logic               t7_deg;

  sqrt_st_t           sk     [0:SqrtSteps];
  logic signed [37:0] sk_rt  [0:SqrtSteps][0:2];
  logic signed [31:0] sk_n   [0:SqrtSteps][0:2];
  logic signed [31:0] sk_pos [0:SqrtSteps][0:2];
  logic               sk_deg [0:SqrtSteps];
  logic               sk_tir [0:SqrtSteps];

  logic signed [63:0] v1_ns [0:2];
  logic signed [37:0] v1_rt [0:2];
  logic signed [31:0] v1_pos [0:2];
  logic               v1_deg;
  logic               v1_tir;

  logic signed [39:0] v2_t [0:2];
  logic signed [31:0] v2_pos [0:2];
  logic               v2_deg;
  logic               v2_tir;

  logic signed [31:0] v3_dir [0:2];
  logic signed [63:0] v3_te [0:2];
  logic signed [31:0] v3_pos [0:2];
  logic               v3_deg;
  logic               v3_tir;

  logic signed [31:0] v4_dir [0:2];
  logic signed [32:0] v4_off [0:2];
  logic signed [31:0] v4_pos [0:2];
  logic               v4_deg;
  logic               v4_tir;

  logic signed [31:0] v5_dir [0:2];
  logic signed [31:0] v5_org [0:2];

  // global advance: the pipeline moves unless a finished word is held
  assign en        = !vld[TotalLat-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld[TotalLat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TotalLat-2:0], in_valid};
    end
  end

  assign dv = '{dir_x, dir_y, dir_z};
  assign nv = '{normal_x, normal_y, normal_z};

  rrd_unitize u_unit_d (.clk(clk), .en(en), .v(dv), .u(ud), .zero(zd));
  rrd_unitize u_unit_n (.clk(clk), .en(en), .v(nv), .u(un), .zero(zn));

  // position and ratio ride along the unitize pipelines
  always_ff @(posedge clk) begin
    if (en) begin
      pu_pos[0] <= '{pos_x, pos_y, pos_z};
      pu_r[0]   <= index_ratio;
    end
  end

  for (genvar j = 1; j < UnitLat; j++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en) begin
        pu_pos[j] <= pu_pos[j-1];
        pu_r[j]   <= pu_r[j-1];
      end
    end
  end

  // products for the dot of d and n
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) t1_dn[i] <= ud[i] * un[i];
      t1_d   <= ud;
      t1_n   <= un;
      t1_pos <= pu_pos[UnitLat-1];
      t1_r   <= pu_r[UnitLat-1];
      t1_deg <= zd || zn;
    end
  end

  // dot sum
  always_ff @(posedge clk) begin
    if (en) begin
      t2_dot <= t1_dn[0] + t1_dn[1] + t1_dn[2];
      t2_d   <= t1_d;
      t2_n   <= t1_n;
      t2_pos <= t1_pos;
      t2_r   <= t1_r;
      t2_deg <= t1_deg;
    end
  end

  // cosine, rounded to Q1.30 and clamped to [-1, 1]
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [63:0] cr;
      cr = rshr(t2_dot, 30);
      if (cr > Q30One) t3_c <= 32'(Q30One);
      else if (cr < -Q30One) t3_c <= 32'(-Q30One);
      else t3_c <= cr[31:0];
      t3_d   <= t2_d;
      t3_n   <= t2_n;
      t3_pos <= t2_pos;
      t3_r   <= t2_r;
      t3_deg <= t2_deg;
    end
  end

  // c squared and n times c
  always_ff @(posedge clk) begin
    if (en) begin
      t4_cc <= t3_c * t3_c;
      for (int i = 0; i < 3; i++) t4_nc[i] <= t3_n[i] * t3_c;
      t4_d   <= t3_d;
      t4_n   <= t3_n;
      t4_pos <= t3_pos;
      t4_r   <= t3_r;
      t4_deg <= t3_deg;
    end
  end

  // one minus c squared, tangential part
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [63:0] omc;
      logic signed [63:0] tg;
      omc = Q30One - rshr(t4_cc, 30);
      t5_omc <= omc[63] ? '0 : omc[30:0];
      for (int i = 0; i < 3; i++) begin
        tg = 64'(t4_d[i]) - rshr(t4_nc[i], 30);
        t5_tang[i] <= tg[32:0];
      end
      t5_n   <= t4_n;
      t5_pos <= t4_pos;
      t5_r   <= t4_r;
      t5_deg <= t4_deg;
    end
  end

  // r times (1 - c*c), r times tangential part
  always_ff @(posedge clk) begin
    if (en) begin
      t6_rom <= 51'(t5_r) * 51'(t5_omc);
      for (int i = 0; i < 3; i++) t6_rtp[i] <= $signed({1'b0, t5_r}) * t5_tang[i];
      t6_n   <= t5_n;
      t6_pos <= t5_pos;
      t6_r   <= t5_r;
      t6_deg <= t5_deg;
    end
  end

  // second factor of r, rounded tangential term
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [63:0] rt;
      t7_rr <= 55'(t6_rom[50:16]) * 55'(t6_r);
      for (int i = 0; i < 3; i++) begin
        rt = rshr(64'(t6_rtp[i]), 16);
        t7_rt[i] <= rt[37:0];
      end
      t7_n   <= t6_n;
      t7_pos <= t6_pos;
      t7_deg <= t6_deg;
    end
  end

  // root argument k, reflection test, root pipeline seed
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [63:0] k;
      k = Q30One - $signed({25'd0, t7_rr[54:16]});
      sk[0].num <= {33'd0, k[30:0]} << 30;
      sk[0].res <= '0;
      sk_tir[0] <= k[63];
      sk_rt[0]  <= t7_rt;
      sk_n[0]   <= t7_n;
      sk_pos[0] <= t7_pos;
      sk_deg[0] <= t7_deg;
    end
  end

  // square root of k, one result bit per stage
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (en) begin
        sk[j+1]     <= sqrt_step(sk[j], 64'd1 << (62 - 2 * j));
        sk_rt[j+1]  <= sk_rt[j];
        sk_n[j+1]   <= sk_n[j];
        sk_pos[j+1] <= sk_pos[j];
        sk_deg[j+1] <= sk_deg[j];
        sk_tir[j+1] <= sk_tir[j];
      end
    end
  end

  // n times sqrt(k)
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v1_ns[i] <= sk_n[SqrtSteps][i] * $signed({1'b0, sk[SqrtSteps].res[30:0]});
      end
      v1_rt  <= sk_rt[SqrtSteps];
      v1_pos <= sk_pos[SqrtSteps];
      v1_deg <= sk_deg[SqrtSteps];
      v1_tir <= sk_tir[SqrtSteps];
    end
  end

  // refracted direction in Q.30
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [63:0] tv;
      for (int i = 0; i < 3; i++) begin
        tv = 64'(v1_rt[i]) - rshr(v1_ns[i], 30);
        v2_t[i] <= tv[39:0];
      end
      v2_pos <= v1_pos;
      v2_deg <= v1_deg;
      v2_tir <= v1_tir;
    end
  end

  // output direction and scaled offset
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [63:0] od;
      for (int i = 0; i < 3; i++) begin
        od = rshr(64'(v2_t[i]), 14);
        v3_dir[i] <= od[31:0];
        v3_te[i]  <= v2_t[i] * EpsQ32;
      end
      v3_pos <= v2_pos;
      v3_deg <= v2_deg;
      v3_tir <= v2_tir;
    end
  end

  // offset rounded to Q16.16
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [63:0] of;
      for (int i = 0; i < 3; i++) begin
        of = rshr(v3_te[i], 46);
        v4_off[i] <= of[32:0];
      end
      v4_dir <= v3_dir;
      v4_pos <= v3_pos;
      v4_deg <= v3_deg;
      v4_tir <= v3_tir;
    end
  end

  // saturated origin and result word
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [33:0] sum;
      for (int i = 0; i < 3; i++) begin
        sum = 34'(v4_pos[i]) + 34'(v4_off[i]);
        if (v4_deg || v4_tir) begin
          v5_dir[i] <= '0;
          v5_org[i] <= '0;
        end else begin
          v5_dir[i] <= v4_dir[i];
          if (sum > 34'sd2147483647) v5_org[i] <= 32'sh7fffffff;
          else if (sum < -34'sd2147483648) v5_org[i] <= 32'sh80000000;
          else v5_org[i] <= sum[31:0];
        end
      end
      degenerate          <= v4_deg;
      internal_reflection <= v4_tir && !v4_deg;
    end
  end

  assign out_dir_x = v5_dir[0];
  assign out_dir_y = v5_dir[1];
  assign out_dir_z = v5_dir[2];
  assign origin_x  = v5_org[0];
  assign origin_y  = v5_org[1];
  assign origin_z  = v5_org[2];

endmodule

// ===== rtl/rrd_check.sv =====
// port-level checks for the refraction pipeline, bound to the top level
module rrd_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_dir_x,
  input logic signed [31:0] out_dir_y,
  input logic signed [31:0] out_dir_z,
  input logic signed [31:0] origin_x,
  input logic signed [31:0] origin_y,
  input logic signed [31:0] origin_z,
  input logic               internal_reflection,
  input logic               degenerate
);

  // a held output word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // a held output word backs up the input side
  a_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while output held");

  // flags are exclusive
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(internal_reflection && degenerate))
    else $error("both flags set");

  // flagged words carry zero vectors
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (internal_reflection || degenerate) |->
      out_dir_x == 0 && out_dir_y == 0 && out_dir_z == 0 &&
      origin_x == 0 && origin_y == 0 && origin_z == 0)
    else $error("flagged word with nonzero vectors");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ray_refract_direction_unit rrd_check u_rrd_check (.*);

// ===== verif/ray_refract_direction_unit_tb.sv =====
// testbench for the snell refraction pipeline: own predictor, scoreboard, random idling
module ray_refract_direction_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrd_pkg::*;

  localparam int QuietLimit = 20000;

  typedef struct packed {
    logic signed [31:0] dx, dy, dz, nx, ny, nz, px, py, pz;
    logic [19:0] ratio;
  } ray_t;

  typedef struct packed {
    logic signed [31:0] tx, ty, tz, ox, oy, oz;
    logic tir, degen;
  } bent_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [31:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [19:0] index_ratio = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_dir_x, out_dir_y, out_dir_z, origin_x, origin_y, origin_z;
  logic internal_reflection, degenerate;

  bent_t expected_rays[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit hold_long = 1'b0;

  ray_refract_direction_unit u_top (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round half away from zero on a right shift
  function automatic longint round_shift(longint v, int n);
    longint unsigned m;
    m = ((v < 0) ? -v : v);
    m = (m + (64'd1 << (n - 1))) >> n;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned num);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > num) bit_w >>= 2;
    while (bit_w != 0) begin
      if (num >= res + bit_w) begin
        num -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // scale to a Q1.30 unit vector; returns 0 on an all-zero vector
  function automatic bit to_unit(input longint v[3], output longint u[3]);
    longint unsigned m[3], mx, len2, len, q;
    mx = 0;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) len2 += m[i] * m[i];
    len = floor_root(len2);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + len / 2) / len;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic bent_t refract(ray_t a);
    bent_t o;
    longint dv[3], nv[3], pv[3], d[3], n[3], t[3], res[6];
    longint c, c2, omc, k, s, r, tang, sum;
    bit okd, okn;
    o = '0;
    dv = '{a.dx, a.dy, a.dz};
    nv = '{a.nx, a.ny, a.nz};
    pv = '{a.px, a.py, a.pz};
    r = a.ratio;
    okd = to_unit(dv, d);
    okn = to_unit(nv, n);
    if (!okd || !okn) begin
      o.degen = 1'b1;
      return o;
    end
    c = round_shift(d[0] * n[0] + d[1] * n[1] + d[2] * n[2], 30);
    if (c > (64'sd1 << 30)) c = 64'sd1 << 30;
    if (c < -(64'sd1 << 30)) c = -(64'sd1 << 30);
    c2 = round_shift(c * c, 30);
    omc = (64'sd1 << 30) - c2;
    if (omc < 0) omc = 0;
    k = (64'sd1 << 30) - ((((r * omc) >>> 16) * r) >>> 16);
    if (k < 0) begin
      o.tir = 1'b1;
      return o;
    end
    s = floor_root(longint'(k) << 30);
    for (int i = 0; i < 3; i++) begin
      tang = d[i] - round_shift(n[i] * c, 30);
      t[i] = round_shift(r * tang, 16) - round_shift(n[i] * s, 30);
      res[i] = round_shift(t[i], 14);
      sum = pv[i] + round_shift(t[i] * 429497, 46);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      res[3 + i] = sum;
    end
    o.tx = res[0][31:0]; o.ty = res[1][31:0]; o.tz = res[2][31:0];
    o.ox = res[3][31:0]; o.oy = res[4][31:0]; o.oz = res[5][31:0];
    return o;
  endfunction

  // send one word, with the given gap before it
  task automatic send_ray(ray_t a, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    {dir_x, dir_y, dir_z, normal_x, normal_y, normal_z,
     pos_x, pos_y, pos_z, index_ratio} <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_rays = {expected_rays, refract(a)};
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return $urandom;
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t a;
    a.dx = rand_coord(); a.dy = rand_coord(); a.dz = rand_coord();
    a.nx = rand_coord(); a.ny = rand_coord(); a.nz = rand_coord();
    a.px = rand_coord(); a.py = rand_coord(); a.pz = rand_coord();
    case ($urandom_range(0, 4))
      0: a.ratio = 20'($urandom_range(0, 20'hfffff));
      1: a.ratio = 20'($urandom_range(20'h0c000, 20'h14000));
      default: a.ratio = 20'($urandom_range(0, 20'h30000));
    endcase
    if ($urandom_range(0, 40) == 0) {a.dx, a.dy, a.dz} = '0;
    if ($urandom_range(0, 40) == 0) {a.nx, a.ny, a.nz} = '0;
    return a;
  endfunction

  function automatic int burst_gap();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
  endfunction

  // extremes, zero vectors, reflection, zero ratio
  task automatic test_directed();
    localparam logic signed [31:0] One = 32'sh0001_0000;
    send_ray('{One, 0, 0, -One, 0, 0, 0, 0, 0, 20'h10000}, 0);
    send_ray('{0, 0, 0, 0, One, 0, 5, 6, 7, 20'h10000}, 0);
    send_ray('{One, One, 0, 0, 0, 0, 5, 6, 7, 20'h10000}, 0);
    send_ray('{0, 0, 0, 0, 0, 0, 0, 0, 0, 20'h00000}, 0);
    send_ray('{One, -One, 0, 0, One, 0, 0, 0, 0, 20'h20000}, 1);
    send_ray('{One, -One, 0, 0, One, 0, 0, 0, 0, 20'hfffff}, 0);
    send_ray('{One, -One, 7, 0, One, 3, 100, -100, 9, 20'h00000}, 0);
    send_ray('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
               32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
               32'sh7fffffff, 20'h10000}, 0);
    send_ray('{32'sh80000000, 1, -1, 1, 0, 0, 32'sh80000000, 32'sh80000000,
               32'sh80000000, 20'h0c000}, 2);
    send_ray('{1, 0, 0, 0, 0, -1, 32'sh7fffffff, 0, 32'sh80000000, 20'h14000}, 0);
    send_ray('{32'shffffffff, 32'shffffffff, 32'shffffffff, 1, 1, 1,
               -3, 3, 0, 20'h0ffff}, 0);
    send_ray('{One, 0, -One, 0, 0, One, 32'sh7fff0000, 32'sh80010000, 0,
               20'h18000}, 0);
    send_ray('{0, 0, One, 0, 0, One, 1, 2, 3, 20'h10000}, 0);
  endtask

  // random rays in bursts with gaps
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_ray(rand_ray(), burst_gap());
  endtask

  // receiver holds off long enough to fill the pipeline
  task automatic test_backpressure();
    hold_long = 1'b1;
    for (int i = 0; i < 200; i++) send_ray(rand_ray(), 0);
    hold_long = 1'b0;
  endtask

  // receiver stall pattern
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 300 && hold_long; i++) @(negedge clk);
        out_stall <= 1'b0;
        wait (!hold_long);
      end else begin
        if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    bent_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{out_dir_x, out_dir_y, out_dir_z, origin_x, origin_y, origin_z,
              internal_reflection, degenerate};
      if (expected_rays.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        want = expected_rays.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(300);
    test_backpressure();
    test_random(150);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rays.size() != 0) @(posedge clk);
    repeat (TotalLat + 10) @(posedge clk);
    if (errors == 0 && !out_valid) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== ray_refract_direction_unit.f =====
rtl/rrd_pkg.sv
rtl/rrd_unitize.sv
rtl/ray_refract_direction_unit.sv
rtl/rrd_check.sv
verif/ray_refract_direction_unit_tb.sv
